@@ hw/rtl/cpa_pkg.sv @@
// Shared types and constants for the contiguous page allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpa_pkg;

  // Field widths
  localparam int REQ_W  = 29;
  localparam int TOP_W  = 16;
  localparam int BASE_W = 16;

  // Page geometry
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  // Page count after round-up of a request
  localparam int N_W = REQ_W + 1 - PAGE_SHIFT;

  // Bitmap word organization
  localparam int WORD_BITS = 32;
  localparam int WORD_LSB  = $clog2(WORD_BITS);

  localparam int MAP_PAGES_DEF = 65536;
  localparam logic [TOP_W-1:0] TOP_RESET = 16'd32768;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_t;

  // Outcome of examining one bitmap word in scan order
  typedef struct packed {
    logic                hit;
    logic [WORD_LSB-1:0] hit_pos;
    logic [N_W-1:0]      run_out;
  } scan_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/cpa_bitmap.sv @@
// Used/free page bitmap: one synchronous memory of 32-bit words.
// Runs a clearing sweep after reset. Depends on cpa_pkg.
`default_nettype none

module cpa_bitmap #(
  parameter int WORDS = 2048,
  parameter int AW    = 11
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [AW-1:0]                  rd_addr,
  output logic      [cpa_pkg::WORD_BITS-1:0]  rd_data,
  input  wire logic                           wr_en,
  input  wire logic [AW-1:0]                  wr_addr,
  input  wire logic [cpa_pkg::WORD_BITS-1:0]  wr_data,
  output logic                                clearing
);
  import cpa_pkg::*;

  logic [WORD_BITS-1:0] mem [0:WORDS-1];
  logic [AW-1:0]        clr_addr;

  // clear sweep, one word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(WORDS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/cpa_word_scan.sv @@
// Examines one 32-page bitmap word from its highest page down.
// Finds the first page that closes a free run long enough. Depends on cpa_pkg.
`default_nettype none

module cpa_word_scan (
  input  wire logic [cpa_pkg::WORD_BITS-1:0] word_data,
  input  wire logic                          first_word,
  input  wire logic [cpa_pkg::WORD_LSB-1:0]  top_bit,
  input  wire logic                          bottom_word,
  input  wire logic [cpa_pkg::N_W-1:0]       run_in,
  input  wire logic [cpa_pkg::N_W-1:0]       need_pages,
  output cpa_pkg::scan_res_t                 res
);
  import cpa_pkg::*;

  logic [WORD_BITS-1:0] used;
  logic [WORD_BITS-1:0] us;          // scan order: index 0 is the highest page
  logic                 hv [0:WORD_LSB][0:WORD_BITS];
  logic [WORD_LSB-1:0]  iv [0:WORD_LSB][0:WORD_BITS];
  logic [N_W-1:0]       need;
  logic [WORD_LSB-1:0]  run_j;
  logic [WORD_LSB-1:0]  tail;
  logic [N_W:0]         sum;
  logic                 cond;

  always_comb begin
    // pages above the start and page 0 count as used
    used = word_data;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (first_word && (WORD_LSB'(b) > top_bit)) begin
        used[b] = 1'b1;
      end
    end
    if (bottom_word) begin
      used[0] = 1'b1;
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      us[j] = used[WORD_BITS-1-j];
    end

    // prefix search: nearest used position above each position
    for (int p = 0; p <= WORD_BITS; p++) begin
      if (p == 0) begin
        hv[0][p] = 1'b0;
        iv[0][p] = '0;
      end else begin
        hv[0][p] = us[p-1];
        iv[0][p] = WORD_LSB'(p - 1);
      end
    end
    for (int l = 0; l < WORD_LSB; l++) begin
      for (int p = 0; p <= WORD_BITS; p++) begin
        if (!hv[l][p] && (p >= (1 << l))) begin
          hv[l+1][p] = hv[l][p-(1<<l)];
          iv[l+1][p] = iv[l][p-(1<<l)];
        end else begin
          hv[l+1][p] = hv[l][p];
          iv[l+1][p] = iv[l][p];
        end
      end
    end

    need = need_pages - run_in;

    res.hit     = 1'b0;
    res.hit_pos = '0;
    run_j       = '0;
    cond        = 1'b0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      run_j = WORD_LSB'(j) - WORD_LSB'(1) - iv[WORD_LSB][j];
      if (hv[WORD_LSB][j]) begin
        cond = !us[j] && (N_W'(run_j) >= need_pages);
      end else begin
        cond = !us[j] && (N_W'(j) >= need);
      end
      if (cond) begin
        res.hit     = 1'b1;
        res.hit_pos = WORD_LSB'(j);
      end
    end

    // free run carried into the next word, capped at the page count
    tail = WORD_LSB'(WORD_BITS - 1) - iv[WORD_LSB][WORD_BITS];
    sum  = (N_W+1)'(run_in) + (N_W+1)'(WORD_BITS);
    if (!hv[WORD_LSB][WORD_BITS]) begin
      res.run_out = (sum >= (N_W+1)'(need_pages)) ? need_pages : N_W'(sum);
    end else begin
      res.run_out = (N_W'(tail) >= need_pages) ? need_pages : N_W'(tail);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/contiguous_page_allocator.sv @@
// First-fit contiguous page allocator, top level.
// Depends on cpa_pkg, cpa_bitmap and cpa_word_scan.
//
// Each request beat carries a byte count, rounded up to n pages of 4 KiB.
// The block scans the used map downward from top_page (capped at the last
// page of the map) toward page 1, one 32-page bitmap word per cycle. The
// first free page that sits directly below n free pages is the answer; pages
// base_page .. base_page+n-1 are then marked used, one word per cycle, by a
// read-modify-write pipeline on the bitmap memory. A zero-byte request gets
// the highest free page and marks nothing. A miss returns found=0 and
// base_page=0. One request is in flight at a time; the scan reads words
// from the word of top_page down to the word of the answer (up to 2048 at
// the default map size) through the single read port of the bitmap memory.
// After reset a clearing sweep writes the whole map free, one word per
// cycle over MAP_PAGES/32 words (2048 by default); no request beat is taken
// until it ends, but configuration beats are accepted at any time.
// A finished result sits in an output register, so the next request beat
// can be taken while that result waits on out_ready.
`default_nettype none

module contiguous_page_allocator #(
  parameter int MAP_PAGES = cpa_pkg::MAP_PAGES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration: top_page
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [cpa_pkg::TOP_W-1:0]    cfg_data,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [cpa_pkg::REQ_W-1:0]    request_bytes,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              found,
  output logic      [cpa_pkg::BASE_W-1:0]   base_page
);
  import cpa_pkg::*;

  localparam int WORDS = (MAP_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = $clog2(MAP_PAGES);

  state_t state, state_next;

  logic [TOP_W-1:0]     top_page;
  logic [N_W-1:0]       n_pages;
  logic [N_W-1:0]       run;          // free pages counted just above the current word
  logic [AW-1:0]        cur_word;     // word whose data is on rd_data during the scan
  logic                 first_word;
  logic [PW-1:0]        hit_page;
  logic [PW-1:0]        last_page;
  logic [AW-1:0]        mark_addr;
  logic [AW-1:0]        mark_end;
  logic                 mark_more;
  logic                 pend;         // a marking read is back on rd_data
  logic [AW-1:0]        pend_addr;
  logic                 res_found;

  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 clearing;

  logic [PW-1:0]        eff_top;
  logic [AW-1:0]        top_word;
  logic [WORD_LSB-1:0]  top_bit;
  logic [N_W-1:0]       n_calc;
  logic [PW-1:0]        hp;
  logic [PW-1:0]        lp;
  logic [WORD_LSB-1:0]  lo_bit;
  logic [WORD_LSB-1:0]  hi_bit;
  logic [WORD_BITS-1:0] mark_mask;
  logic                 slot_free;
  scan_res_t            scan_res;

  cpa_bitmap #(
    .WORDS(WORDS),
    .AW   (AW)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .clearing(clearing)
  );

  cpa_word_scan u_scan (
    .word_data  (rd_data),
    .first_word (first_word),
    .top_bit    (top_bit),
    .bottom_word(cur_word == '0),
    .run_in     (run),
    .need_pages (n_pages),
    .res        (scan_res)
  );

  // start page, capped to the map; pages past the map read as used
  always_comb begin
    if (32'(top_page) >= 32'(MAP_PAGES)) begin
      eff_top = PW'(MAP_PAGES - 1);
    end else begin
      eff_top = PW'(top_page);
    end
    top_word = AW'(32'(eff_top) >> WORD_LSB);
    top_bit  = WORD_LSB'(32'(eff_top));
    n_calc   = N_W'(((REQ_W+1)'(request_bytes) + (REQ_W+1)'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
    // bit position in the word is the inverse of the scan position
    hp       = PW'({cur_word, ~scan_res.hit_pos});
    lp       = PW'(32'(hp) + 32'(n_pages) - 32'd1);
    slot_free = !out_valid || out_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (!clearing) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_res.hit) begin
          state_next = (n_pages == '0) ? ST_DONE : ST_MARK;
        end else if (cur_word == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_MARK: begin
        if (!mark_more && pend) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b1;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = pend_addr;
    lo_bit    = (pend_addr == AW'(32'(hit_page) >> WORD_LSB)) ?
                WORD_LSB'(32'(hit_page)) : '0;
    hi_bit    = (pend_addr == mark_end) ? WORD_LSB'(32'(last_page)) :
                WORD_LSB'(WORD_BITS - 1);
    mark_mask = ({WORD_BITS{1'b1}} << lo_bit) &
                ({WORD_BITS{1'b1}} >> (WORD_LSB'(WORD_BITS - 1) - hi_bit));
    wr_data   = rd_data | mark_mask;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = top_word;
      end
      ST_SCAN: begin
        // fetch the next word down ahead of the decision
        rd_addr = (cur_word == '0) ? '0 : cur_word - AW'(1);
      end
      ST_MARK: begin
        rd_addr = mark_addr;
        wr_en   = pend;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      top_page  <= TOP_RESET;
      out_valid <= 1'b0;
      mark_more <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        top_page <= cfg_data;
      end
      if (state == ST_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_SCAN: begin
          if (scan_res.hit) begin
            mark_more <= 1'b1;
            pend      <= 1'b0;
          end
        end
        ST_MARK: begin
          pend <= mark_more;
          if (mark_more && (mark_addr == mark_end)) begin
            mark_more <= 1'b0;
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n_pages    <= n_calc;
        run        <= '0;
        cur_word   <= top_word;
        first_word <= 1'b1;
      end
      ST_SCAN: begin
        if (scan_res.hit) begin
          res_found <= 1'b1;
          hit_page  <= hp;
          last_page <= lp;
          mark_addr <= AW'(32'(hp) >> WORD_LSB);
          mark_end  <= AW'(32'(lp) >> WORD_LSB);
        end else if (cur_word == '0) begin
          res_found <= 1'b0;
        end else begin
          cur_word   <= cur_word - AW'(1);
          first_word <= 1'b0;
          run        <= scan_res.run_out;
        end
      end
      ST_MARK: begin
        if (mark_more) begin
          pend_addr <= mark_addr;
          if (mark_addr != mark_end) begin
            mark_addr <= mark_addr + AW'(1);
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          found     <= res_found;
          base_page <= res_found ? BASE_W'(32'(hit_page)) : '0;
        end
      end
      default: begin
        run <= run;
      end
    endcase
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !wr_en)
    else $error("bitmap written during scan");

  a_mark_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr_en && mark_more) |-> (wr_addr != mark_addr))
    else $error("marking read and write hit the same word");

  a_run_capped: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (run <= n_pages))
    else $error("free run count above page count");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (base_page == '0))
    else $error("miss result carries a page");

  a_hit_not_page0: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (base_page != '0))
    else $error("page 0 returned");

endmodule

`default_nettype wire
